### rtl/sssp_pkg.sv
package sssp_pkg;

  localparam int NODE_FIELD_W = 9;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int NODE_COUNT_DEF    = 512;
  localparam int EDGE_CAPACITY_DEF = 8192;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_QCLR,
    ST_SEED,
    ST_POP,
    ST_FETCH,
    ST_SCAN,
    ST_EDGE,
    ST_LOAD,
    ST_RELAX,
    ST_FIN,
    ST_RES
  } state_t;

endpackage

### rtl/sssp_in_if.sv
interface sssp_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic [sssp_pkg::NODE_FIELD_W-1:0]   from_node;
  logic [sssp_pkg::NODE_FIELD_W-1:0]   to_node;
  logic [sssp_pkg::WEIGHT_W-1:0]       weight;

  modport source(output valid, command, from_node, to_node, weight, input ready);
  modport sink(input valid, command, from_node, to_node, weight, output ready);
endinterface

### rtl/sssp_out_if.sv
interface sssp_out_if;
  logic                          valid;
  logic                          ready;
  logic [sssp_pkg::DIST_W-1:0]   distance;
  logic                          reachable;
  logic                          edges_dropped;

  modport source(output valid, distance, reachable, edges_dropped, input ready);
  modport sink(input valid, distance, reachable, edges_dropped, output ready);
endinterface

### rtl/single_source_shortest_path.sv
// Queue-based Bellman-Ford (SPFA) engine. An add-edge transaction is taken every
// cycle in steady state (the list-head update is forwarded between back-to-back
// adds to the same node); clear-graph and reset both sweep the list-head memory
// with the input stalled. A query first sweeps the node-state memory, seeds the
// source if it is in range, then dequeues nodes and scans each one's edge list
// until the queue is empty, then returns the result, later if the previous result
// still waits on the output; every step waits on the registered read of the
// node-state and edge memories.
// Edge adds are accepted while a query result still waits on the output.
module single_source_shortest_path #(
  parameter int NODE_COUNT    = sssp_pkg::NODE_COUNT_DEF,
  parameter int EDGE_CAPACITY = sssp_pkg::EDGE_CAPACITY_DEF
) (
  input  logic  clk,
  input  logic  rst,
  sssp_in_if.sink    in_ch,
  sssp_out_if.source out_ch
);
  import sssp_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $clog2(EDGE_CAPACITY);
  localparam int PW = $clog2(EDGE_CAPACITY + 1);
  localparam int FW = $clog2(NODE_COUNT + 1);
  localparam int EDGE_W = PW + NW + WEIGHT_W;
  localparam int NODE_W = DIST_W + 2;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [PW-1:0] CAP = PW'(EDGE_CAPACITY);

  state_t state, state_next;

  logic [NW-1:0]       sweep;
  logic [NW-1:0]       top;
  logic [DIST_W-1:0]   top_dist;
  logic [PW-1:0]       ptr;
  logic [DIST_W-1:0]   nd;
  logic [NW-1:0]       to_r;
  logic [NW-1:0]       qhead, qtail;
  logic [FW-1:0]       qfill;
  logic [NODE_FIELD_W-1:0] src, tgt;
  logic [PW-1:0]       edge_count;
  logic                drop;
  logic                add_pend, add_fwd;
  logic [NW-1:0]       add_u, add_v;
  logic [WEIGHT_W-1:0] add_w;
  logic                res_valid, res_reach, res_drop;
  logic [DIST_W-1:0]   res_dist;

  logic accept, in_add_ok, add_full, src_ok, tgt_ok, relax_upd;
  logic [PW-1:0] head_val;
  logic [DIST_W:0] sum;

  // memory ports
  logic              head_we;
  logic [NW-1:0]     head_waddr, head_raddr;
  logic [PW-1:0]     head_wdata, head_rdata;
  logic              edge_we;
  logic [EW-1:0]     edge_waddr, edge_raddr;
  logic [EDGE_W-1:0] edge_wdata, edge_rdata;
  logic              node_we;
  logic [NW-1:0]     node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_raddr;
  logic [NW-1:0]     q_wdata, q_rdata;

  logic              n_inq, n_reached;
  logic [DIST_W-1:0] n_dist;
  logic [PW-1:0]     e_next;
  logic [NW-1:0]     e_target;
  logic [WEIGHT_W-1:0] e_weight;

  function automatic logic [NW-1:0] wrap_inc(input logic [NW-1:0] x);
    return (x == LAST_NODE) ? '0 : x + 1'b1;
  endfunction

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_add_ok   = (32'(in_ch.from_node) < NODE_COUNT) && (32'(in_ch.to_node) < NODE_COUNT);
  assign add_full    = (edge_count == CAP);
  assign head_val    = add_fwd ? edge_count : head_rdata;
  assign src_ok      = (32'(src) < NODE_COUNT);
  assign tgt_ok      = (32'(tgt) < NODE_COUNT);

  assign {n_inq, n_reached, n_dist}      = node_rdata;
  assign {e_next, e_target, e_weight}    = edge_rdata;
  assign sum       = {1'b0, top_dist} + (DIST_W + 1)'(e_weight);
  assign relax_upd = !n_reached || (nd < n_dist);

  assign out_ch.valid         = res_valid;
  assign out_ch.distance      = res_dist;
  assign out_ch.reachable     = res_reach;
  assign out_ch.edges_dropped = res_drop;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:   if (sweep == LAST_NODE) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            CMD_QUERY: state_next = ST_QCLR;
            CMD_CLEAR: state_next = ST_CLR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_QCLR:  if (sweep == LAST_NODE) state_next = src_ok ? ST_SEED : ST_FIN;
      ST_SEED:  state_next = ST_POP;
      ST_POP:   state_next = (qfill == '0) ? ST_FIN : ST_FETCH;
      ST_FETCH: state_next = ST_SCAN;
      ST_SCAN:  state_next = ST_EDGE;
      ST_EDGE:  state_next = (ptr == '0) ? ST_POP : ST_LOAD;
      ST_LOAD:  state_next = ST_RELAX;
      ST_RELAX: state_next = ST_EDGE;
      ST_FIN:   state_next = ST_RES;
      ST_RES:   if (!res_valid || out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_CLR;
    endcase
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = add_u;
    head_wdata = edge_count + 1'b1;
    head_raddr = NW'(in_ch.from_node);
    edge_we    = add_pend && !add_full;
    edge_waddr = EW'(edge_count);
    edge_wdata = {head_val, add_v, add_w};
    edge_raddr = EW'(ptr - 1'b1);
    node_we    = 1'b0;
    node_waddr = sweep;
    node_wdata = '0;
    node_raddr = NW'(tgt);
    q_we       = 1'b0;
    q_waddr    = qtail;
    q_wdata    = to_r;
    q_raddr    = qhead;
    if (add_pend && !add_full) head_we = 1'b1;
    case (state)
      ST_CLR: begin
        head_we    = 1'b1;
        head_waddr = sweep;
        head_wdata = '0;
      end
      ST_QCLR: node_we = 1'b1;
      ST_SEED: begin
        node_we    = 1'b1;
        node_waddr = NW'(src);
        node_wdata = {1'b1, 1'b1, {DIST_W{1'b0}}};
        q_we       = 1'b1;
        q_wdata    = NW'(src);
      end
      ST_FETCH: begin
        node_raddr = q_rdata;
        head_raddr = q_rdata;
      end
      ST_SCAN: begin
        node_we    = 1'b1;
        node_waddr = top;
        node_wdata = {1'b0, n_reached, n_dist};
      end
      ST_LOAD: node_raddr = e_target;
      ST_RELAX: begin
        node_we    = relax_upd;
        node_waddr = to_r;
        node_wdata = {1'b1, 1'b1, nd};
        q_we       = relax_upd && !n_inq;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      sweep      <= '0;
      edge_count <= '0;
      drop       <= 1'b0;
      add_pend   <= 1'b0;
      add_fwd    <= 1'b0;
      res_valid  <= 1'b0;
      qhead      <= '0;
      qtail      <= '0;
      qfill      <= '0;
    end else begin
      state <= state_next;
      sweep <= (state == ST_CLR || state == ST_QCLR) ? sweep + 1'b1 : '0;

      // pending edge insert, in the cycle after its transaction
      if (add_pend) begin
        if (add_full) drop <= 1'b1;
        else edge_count <= edge_count + 1'b1;
      end
      add_pend <= accept && (in_ch.command == CMD_ADD) && in_add_ok;
      add_fwd  <= add_pend && (add_u == NW'(in_ch.from_node));
      if (accept && in_ch.command == CMD_CLEAR) begin
        edge_count <= '0;
        drop       <= 1'b0;
      end

      if (out_ch.ready) res_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          qhead <= '0;
          qtail <= '0;
          qfill <= '0;
        end
        ST_SEED: begin
          qtail <= wrap_inc(qtail);
          qfill <= qfill + 1'b1;
        end
        ST_POP: begin
          if (qfill != '0) begin
            qhead <= wrap_inc(qhead);
            qfill <= qfill - 1'b1;
          end
        end
        ST_RELAX: begin
          if (relax_upd && !n_inq) begin
            qtail <= wrap_inc(qtail);
            qfill <= qfill + 1'b1;
          end
        end
        ST_RES: begin
          if (!res_valid || out_ch.ready) res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      add_u <= NW'(in_ch.from_node);
      add_v <= NW'(in_ch.to_node);
      add_w <= in_ch.weight;
      src   <= in_ch.from_node;
      tgt   <= in_ch.to_node;
    end
    case (state)
      ST_FETCH: top <= q_rdata;
      ST_SCAN: begin
        top_dist <= n_dist;
        ptr      <= head_rdata;
      end
      ST_LOAD: begin
        nd   <= (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
        to_r <= e_target;
        ptr  <= e_next;
      end
      ST_RES: begin
        if (!res_valid || out_ch.ready) begin
          res_reach <= tgt_ok && n_reached;
          res_dist  <= (tgt_ok && n_reached) ? n_dist : '0;
          res_drop  <= drop;
        end
      end
      default: ;
    endcase
  end

  sssp_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  sssp_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_CAPACITY)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  sssp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  sssp_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

endmodule

### rtl/sssp_ram.sv
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### dv/single_source_shortest_path_tb.sv
`timescale 1ns / 1ps

module single_source_shortest_path_tb;
  import sssp_pkg::*;

  localparam int NODES    = NODE_COUNT_DEF;
  localparam int CAPACITY = EDGE_CAPACITY_DEF;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              edges_dropped;
  } route_t;

  // Graph mirror and pending answers.
  class route_board;
    int unsigned head[NODES];
    int unsigned nxt[CAPACITY];
    int unsigned dst[CAPACITY];
    int unsigned wgt[CAPACITY];
    int unsigned n_edges;
    bit          dropped;
    route_t      pending[$];
    int          errors;

    function void wipe();
      foreach (head[i]) head[i] = 0;
      n_edges = 0;
      dropped = 0;
    endfunction

    function route_t shortest(int unsigned src, int unsigned tgt);
      int unsigned node_dist[NODES];
      bit          seen[NODES];
      bit          queued[NODES];
      int unsigned fifo[$];
      int unsigned u, p, e, v, nd;
      route_t      r;
      r = '0;
      r.edges_dropped = dropped;
      foreach (node_dist[i]) begin
        node_dist[i] = 0; seen[i] = 0; queued[i] = 0;
      end
      if (src < NODES) begin
        seen[src] = 1;
        queued[src] = 1;
        fifo.push_back(src);
      end
      while (fifo.size() > 0) begin
        u = fifo.pop_front();
        queued[u] = 0;
        p = head[u];
        while (p != 0) begin
          e = p - 1;
          v = dst[e];
          nd = node_dist[u] + wgt[e];
          if (nd > DIST_MAX) nd = DIST_MAX;
          if (!seen[v] || nd < node_dist[v]) begin
            seen[v] = 1;
            node_dist[v] = nd;
            if (!queued[v]) begin
              queued[v] = 1;
              fifo.push_back(v);
            end
          end
          p = nxt[e];
        end
      end
      if (tgt < NODES && seen[tgt]) begin
        r.distance = DIST_W'(node_dist[tgt]);
        r.reachable = 1;
      end
      return r;
    endfunction

    function void note(logic [1:0] cmd, int unsigned a, int unsigned b, int unsigned w);
      case (cmd)
        CMD_ADD: begin
          if (a < NODES && b < NODES) begin
            if (n_edges >= CAPACITY) dropped = 1;
            else begin
              nxt[n_edges] = head[a];
              dst[n_edges] = b;
              wgt[n_edges] = w;
              n_edges++;
              head[a] = n_edges;
            end
          end
        end
        CMD_CLEAR: wipe();
        CMD_QUERY: pending.push_back(shortest(a, b));
        default: ;
      endcase
    endfunction

    function void check(route_t got);
      route_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, actual %0d", want.distance, got.distance);
        errors++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0d, actual %0d", want.reachable, got.reachable);
        errors++;
      end
      if (got.edges_dropped !== want.edges_dropped) begin
        $error("edges_dropped: expected %0d, actual %0d", want.edges_dropped,
               got.edges_dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  sssp_in_if  in_ch();
  sssp_out_if out_ch();
  route_board board;
  bit         sending_done = 0;

  single_source_shortest_path i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.command = 0;
    in_ch.from_node = 0;
    in_ch.to_node = 0;
    in_ch.weight = 0;
    out_ch.ready = 0;
  end

  int max_gap = 16;

  task automatic send(logic [1:0] cmd, logic [8:0] a, logic [8:0] b, logic [15:0] w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1;
    in_ch.command   <= cmd;
    in_ch.from_node <= a;
    in_ch.to_node   <= b;
    in_ch.weight    <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note(cmd, a, b, w);
  endtask

  // Small node ids keep the graph dense enough for real paths.
  task automatic random_item();
    int unsigned r, span;
    logic [1:0] cmd;
    logic [8:0] a, b;
    logic [15:0] w;
    r = $urandom_range(0, 99);
    span = ($urandom_range(0, 4) == 0) ? 511 : 31;
    a = 9'($urandom_range(0, span));
    b = 9'($urandom_range(0, span));
    w = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    if (r < 62) cmd = CMD_ADD;
    else if (r < 95) cmd = CMD_QUERY;
    else if (r < 98) cmd = CMD_CLEAR;
    else cmd = 2'd3;
    send(cmd, a, b, w);
  endtask

  initial begin
    int i;
    board = new();
    board.wipe();
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed
    send(CMD_QUERY, 9'd0, 9'd0, 16'd0);
    send(CMD_QUERY, 9'd3, 9'd4, 16'd0);
    send(CMD_ADD, 9'd0, 9'd1, 16'hFFFF);
    send(CMD_ADD, 9'd1, 9'd2, 16'hFFFF);
    send(CMD_ADD, 9'd0, 9'd2, 16'd0);
    send(CMD_ADD, 9'd2, 9'd511, 16'd5);
    send(CMD_ADD, 9'd511, 9'd0, 16'h5555);
    send(CMD_ADD, 9'd511, 9'd511, 16'hAAAA);
    send(CMD_QUERY, 9'd0, 9'd1, 16'd0);
    send(CMD_QUERY, 9'd0, 9'd511, 16'hFFFF);
    send(CMD_QUERY, 9'd511, 9'd2, 16'd0);
    send(CMD_QUERY, 9'd1, 9'd0, 16'd0);
    send(2'd3, 9'h1FF, 9'h1FF, 16'hFFFF);
    // long chain of max weights
    for (i = 0; i < 8; i++) send(CMD_ADD, 9'(10 + i), 9'(11 + i), 16'hFFFF);
    send(CMD_QUERY, 9'd10, 9'd18, 16'd0);
    send(CMD_CLEAR, 9'd0, 9'd0, 16'd0);
    send(CMD_QUERY, 9'd0, 9'd1, 16'd0);
    // no-stall stretch, then random
    max_gap = 0;
    for (i = 0; i < 60; i++) random_item();
    max_gap = 16;
    for (i = 0; i < 760; i++) random_item();
    // tail: queries around a clear
    max_gap = 0;
    send(CMD_ADD, 9'd1, 9'd2, 16'd1);
    send(CMD_QUERY, 9'd0, 9'd5, 16'd0);
    send(CMD_QUERY, 9'd7, 9'd7, 16'd0);
    send(CMD_CLEAR, 9'd0, 9'd0, 16'd0);
    send(CMD_QUERY, 9'd1, 9'd2, 16'd0);
    in_ch.valid <= 0;
    sending_done = 1;
  end

  initial begin
    int gap;
    route_t got;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.distance = out_ch.distance;
      got.reachable = out_ch.reachable;
      got.edges_dropped = out_ch.edges_dropped;
      board.check(got);
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #500ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/sssp_pkg.sv
rtl/sssp_in_if.sv
rtl/sssp_out_if.sv
rtl/sssp_ram.sv
rtl/single_source_shortest_path.sv
dv/single_source_shortest_path_tb.sv
